### hw/rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and arithmetic for the subtractive random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

    // Field and table geometry.
    localparam int SEED_W    = 29;
    localparam int VAL_W     = 30;
    localparam int PTR_W     = 6;
    localparam int TABLE_LEN = 55;
    localparam int DEPTH     = TABLE_LEN + 1;
    localparam int PASS_W    = 2;

    // Algorithm constants.
    localparam logic [VAL_W-1:0] MODULUS     = VAL_W'(1000000000);
    localparam logic [VAL_W-1:0] SEED_BASE   = VAL_W'(161803123);
    localparam logic [PTR_W-1:0] FILL_STRIDE = PTR_W'(21);
    localparam logic [PTR_W-1:0] LEN_P       = PTR_W'(TABLE_LEN);
    localparam logic [PTR_W-1:0] LAG         = PTR_W'(31);
    localparam logic [PTR_W-1:0] MIX_OFFSET  = PTR_W'(30);
    localparam logic [PASS_W-1:0] LAST_PASS  = PASS_W'(3);

    // Mixing partner 1 + (i + offset) mod len, split at the wrap point.
    localparam logic [PTR_W-1:0] MIX_SPLIT = LEN_P - MIX_OFFSET - PTR_W'(1);
    localparam logic [PTR_W-1:0] MIX_UP    = MIX_OFFSET + PTR_W'(1);
    localparam logic [PTR_W-1:0] MIX_DOWN  = LEN_P - MIX_OFFSET - PTR_W'(1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } t_state;

    // Difference modulo the modulus for two reduced operands.
    function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] wide;
        begin
            if (a >= b) begin
                wide = {1'b0, a} - {1'b0, b};
            end else begin
                wide = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
            end
            return wide[VAL_W-1:0];
        end
    endfunction

endpackage

### hw/rtl/srg_ram.sv
// ----------------------------------------------------------------------------
// srg_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module srg_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hw/rtl/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive generator: a 55-word table in RAM, reseeded on demand.
// ----------------------------------------------------------------------------
// A request without reseed reads the table RAM as it is accepted, then writes
// its new word back in ST_DRAW_WR and loads it into the output register; no
// new request is taken before that write. A reseed fills the 55 words, mixes
// them (ST_MIX_RD, ST_MIX_WR) up to LAST_PASS, then draws via ST_DRAW_RD/WR.
// Reset clears the controller, pointers and seeded flag; the table RAM is not
// cleared, since the first request always reseeds it.
module subtractive_random_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [srg_pkg::SEED_W-1:0]   i_seed,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [srg_pkg::VAL_W-1:0]    o_random_value,
    output logic                                o_reseeded
);

    srg_pkg::t_state r_state, n_state;

    logic [srg_pkg::PTR_W-1:0]  r_ptr_a, r_ptr_b;
    logic [srg_pkg::PTR_W-1:0]  r_cnt, r_idx, r_i;
    logic [srg_pkg::PASS_W-1:0] r_pass;
    logic [srg_pkg::VAL_W-1:0]  r_mj, r_mk;
    logic                       r_seeded, r_reseed;
    logic                       r_out_valid, r_out_reseeded;
    logic [srg_pkg::VAL_W-1:0]  r_out_value;

    logic                       w_accept, w_do_reseed, w_neg;
    logic [srg_pkg::SEED_W-1:0] w_mag;
    logic [srg_pkg::VAL_W-1:0]  w_mag_sat, w_start;
    logic [srg_pkg::PTR_W-1:0]  w_adv_a, w_adv_b, w_mix_idx, w_idx_step;
    logic [srg_pkg::PTR_W:0]    w_idx_sum;
    logic                       w_we;
    logic [srg_pkg::PTR_W-1:0]  w_waddr, w_raddr_a, w_raddr_b;
    logic [srg_pkg::VAL_W-1:0]  w_wdata, w_rdata_a, w_rdata_b, w_diff;

    // Input handshake: take a word only when idle and the output slot frees up.
    assign o_stall  = (r_state != srg_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    // Seed magnitude, saturated, and the resulting start word.
    assign w_neg       = i_seed[srg_pkg::SEED_W-1];
    assign w_mag       = w_neg ? (~i_seed + srg_pkg::SEED_W'(1)) : i_seed;
    assign w_mag_sat   = (srg_pkg::VAL_W'(w_mag) > srg_pkg::SEED_BASE) ?
                         srg_pkg::SEED_BASE : srg_pkg::VAL_W'(w_mag);
    assign w_start     = srg_pkg::SEED_BASE - w_mag_sat;
    assign w_do_reseed = w_neg || !r_seeded;

    // Cyclic pointer advance over 1..55.
    assign w_adv_a = (r_ptr_a >= srg_pkg::LEN_P) ? srg_pkg::PTR_W'(1)
                                                 : r_ptr_a + srg_pkg::PTR_W'(1);
    assign w_adv_b = (r_ptr_b >= srg_pkg::LEN_P) ? srg_pkg::PTR_W'(1)
                                                 : r_ptr_b + srg_pkg::PTR_W'(1);

    // Mixing partner and fill order step. The stride sum needs one extra bit.
    assign w_mix_idx  = (r_i <= srg_pkg::MIX_SPLIT) ? r_i + srg_pkg::MIX_UP
                                                    : r_i - srg_pkg::MIX_DOWN;
    assign w_idx_sum  = {1'b0, r_idx} + {1'b0, srg_pkg::FILL_STRIDE};
    assign w_idx_step = (w_idx_sum >= {1'b0, srg_pkg::LEN_P}) ?
                        srg_pkg::PTR_W'(w_idx_sum - {1'b0, srg_pkg::LEN_P}) :
                        w_idx_sum[srg_pkg::PTR_W-1:0];

    assign w_diff = srg_pkg::mod_sub(w_rdata_a, w_rdata_b);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and table port control.
    always_comb begin
        n_state   = r_state;
        w_we      = 1'b0;
        w_waddr   = r_ptr_a;
        w_wdata   = w_diff;
        w_raddr_a = w_adv_a;
        w_raddr_b = w_adv_b;
        case (r_state)
            srg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_do_reseed ? srg_pkg::ST_FILL : srg_pkg::ST_DRAW_WR;
                end
            end
            srg_pkg::ST_FILL: begin
                w_we = 1'b1;
                if (r_cnt == '0) begin
                    w_waddr = srg_pkg::LEN_P;
                    w_wdata = r_mj;
                end else begin
                    w_waddr = r_idx;
                    w_wdata = r_mk;
                end
                if (r_cnt == srg_pkg::LEN_P - srg_pkg::PTR_W'(1)) begin
                    n_state = srg_pkg::ST_MIX_RD;
                end
            end
            srg_pkg::ST_MIX_RD: begin
                w_raddr_a = r_i;
                w_raddr_b = w_mix_idx;
                n_state   = srg_pkg::ST_MIX_WR;
            end
            srg_pkg::ST_MIX_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                if (r_i == srg_pkg::LEN_P && r_pass == srg_pkg::LAST_PASS) begin
                    n_state = srg_pkg::ST_DRAW_RD;
                end else begin
                    n_state = srg_pkg::ST_MIX_RD;
                end
            end
            srg_pkg::ST_DRAW_RD: begin
                w_raddr_a = r_ptr_a;
                w_raddr_b = r_ptr_b;
                n_state   = srg_pkg::ST_DRAW_WR;
            end
            srg_pkg::ST_DRAW_WR: begin
                w_we    = 1'b1;
                n_state = srg_pkg::ST_IDLE;
            end
            default: begin
                n_state = srg_pkg::ST_IDLE;
            end
        endcase
    end

    // Pointers and seeded flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_a  <= '0;
            r_ptr_b  <= '0;
            r_seeded <= 1'b0;
        end else if (w_accept) begin
            if (w_do_reseed) begin
                r_seeded <= 1'b1;
            end else begin
                r_ptr_a <= w_adv_a;
                r_ptr_b <= w_adv_b;
            end
        end else if (r_state == srg_pkg::ST_MIX_WR && n_state == srg_pkg::ST_DRAW_RD) begin
            // Pointers restart at 0 and the lag, then advance once for this draw.
            r_ptr_a <= srg_pkg::PTR_W'(1);
            r_ptr_b <= srg_pkg::LAG + srg_pkg::PTR_W'(1);
        end
    end

    // Reseed sequencer: fill registers, mixing index and pass count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_reseed <= w_do_reseed;
            r_mj     <= w_start;
            r_mk     <= srg_pkg::VAL_W'(1);
            r_cnt    <= '0;
            r_idx    <= srg_pkg::FILL_STRIDE;
            r_i      <= srg_pkg::PTR_W'(1);
            r_pass   <= '0;
        end else begin
            case (r_state)
                srg_pkg::ST_FILL: begin
                    r_cnt <= r_cnt + srg_pkg::PTR_W'(1);
                    if (r_cnt != '0) begin
                        r_mk  <= srg_pkg::mod_sub(r_mj, r_mk);
                        r_mj  <= r_mk;
                        r_idx <= w_idx_step;
                    end
                end
                srg_pkg::ST_MIX_WR: begin
                    if (r_i == srg_pkg::LEN_P) begin
                        r_i    <= srg_pkg::PTR_W'(1);
                        r_pass <= r_pass + srg_pkg::PASS_W'(1);
                    end else begin
                        r_i <= r_i + srg_pkg::PTR_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == srg_pkg::ST_DRAW_WR) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srg_pkg::ST_DRAW_WR) begin
            r_out_value    <= w_diff;
            r_out_reseeded <= r_reseed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_value;
    assign o_reseeded     = r_out_reseeded;

    // Lag table.
    srg_ram #(
        .WIDTH (srg_pkg::VAL_W),
        .DEPTH (srg_pkg::DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // The table is never written while waiting for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srg_pkg::ST_IDLE) |-> !w_we)
        else $error("table written while idle");

    // A result word is loaded only into an empty output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srg_pkg::ST_DRAW_WR) |-> !r_out_valid)
        else $error("output register overwritten");

    // A request on a seeded generator with a non-negative seed draws at once.
    a_fast_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_seeded && !w_neg) |=> (r_state == srg_pkg::ST_DRAW_WR))
        else $error("draw did not follow request");

    // Pointers stay in 1..55 between requests once seeded.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srg_pkg::ST_IDLE && r_seeded) |->
        (r_ptr_a >= srg_pkg::PTR_W'(1) && r_ptr_a <= srg_pkg::LEN_P &&
         r_ptr_b >= srg_pkg::PTR_W'(1) && r_ptr_b <= srg_pkg::LEN_P))
        else $error("pointer out of range");

endmodule
